// File: rtl/mpqs_pkg.sv
// ----------------------------------------------------------------------------
// mpqs_pkg: shared types and constants of the max priority queue
// Queue depth, field widths and the status codes returned with every item.
// ----------------------------------------------------------------------------
package mpqs_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    typedef logic [DATA_W-1:0] word_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

// File: rtl/max_priority_queue_scan.sv
// ----------------------------------------------------------------------------
// max_priority_queue_scan: bounded max-priority queue over an unsorted array
//
// Input channel s_*: s_operation selects insert (0) or remove (1); s_value
// is the signed value to insert and is ignored on remove. Result channel
// m_*: one item per input item with a status (done, insert dropped because
// full, remove on empty), the count held after the item and the largest
// held value with a valid flag (value reads zero when the queue is empty).
// An insert, a failed item and the removal of the last entry complete in
// the accept cycle; the result shows on the next cycle. A remove that
// leaves n > 0 entries runs one pass over those n entries through a single
// read port on the entry array: each cycle reads one entry, moves it down
// over the gap if it lies above the removed slot, and compares it against
// the running maximum. The largest value and its first index are cached,
// so inserts need no pass.
// Reset empties the queue; entry contents are not cleared. The result sits
// in an output register: a stalled receiver holds it, and the next item is
// accepted only once that register is empty or being taken in that cycle.
// ----------------------------------------------------------------------------
module max_priority_queue_scan (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic signed [31:0]          s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic signed [31:0]          m_top_value,
    output logic                        m_top_valid,
    output logic [mpqs_pkg::COUNT_W-1:0] m_count
);
    import mpqs_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                 state_reg;
    word_t                  entries_reg [DEPTH];
    logic [CNT_W-1:0]       occ_reg;
    word_t                  top_reg;
    logic [IDX_W-1:0]       top_idx_reg;
    logic [IDX_W-1:0]       scan_idx_reg;
    word_t                  best_reg;
    logic [IDX_W-1:0]       best_idx_reg;

    logic                   m_valid_reg;
    status_t                m_status_reg;
    word_t                  m_top_value_reg;
    logic                   m_top_valid_reg;
    logic [COUNT_W-1:0]     m_count_reg;

    logic                   accept;
    logic                   is_full;
    logic                   is_empty;
    logic [IDX_W-1:0]       rd_addr;
    word_t                  rd_data;
    logic                   take;
    word_t                  best_next;
    logic [IDX_W-1:0]       best_idx_next;
    logic                   scan_last;
    logic [CNT_W-1:0]       occ_dec;
    logic                   ins_new_top;

    assign s_ready  = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign is_full  = (occ_reg == CNT_W'(DEPTH));
    assign is_empty = (occ_reg == '0);
    assign occ_dec  = occ_reg - CNT_W'(1);

    // Skip over the removed slot: entries at or above it come from one place up.
    assign rd_addr = (scan_idx_reg < top_idx_reg) ? scan_idx_reg
                                                  : scan_idx_reg + IDX_W'(1);
    assign rd_data = entries_reg[rd_addr];

    // Strict compare keeps the lowest index among equal maxima.
    assign take          = (scan_idx_reg == '0) || ($signed(rd_data) > $signed(best_reg));
    assign best_next     = take ? rd_data : best_reg;
    assign best_idx_next = take ? scan_idx_reg : best_idx_reg;
    assign scan_last     = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == occ_dec);

    assign ins_new_top = is_empty || ($signed(s_value) > $signed(top_reg));

    always_ff @(posedge aclk) begin
        if (accept && (s_operation == OP_INSERT) && !is_full) begin
            entries_reg[occ_reg[IDX_W-1:0]] <= s_value;
        end else if (state_reg == S_SCAN && scan_idx_reg >= top_idx_reg) begin
            entries_reg[scan_idx_reg] <= rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            top_reg      <= '0;
            top_idx_reg  <= '0;
            scan_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_operation == OP_INSERT) begin
                            m_valid_reg     <= 1'b1;
                            m_top_valid_reg <= 1'b1;
                            if (is_full) begin
                                m_status_reg    <= ST_FULL;
                                m_top_value_reg <= top_reg;
                                m_count_reg     <= COUNT_W'(occ_reg);
                            end else begin
                                occ_reg         <= occ_reg + CNT_W'(1);
                                m_status_reg    <= ST_DONE;
                                m_count_reg     <= COUNT_W'(occ_reg + CNT_W'(1));
                                if (ins_new_top) begin
                                    top_reg         <= s_value;
                                    top_idx_reg     <= occ_reg[IDX_W-1:0];
                                    m_top_value_reg <= s_value;
                                end else begin
                                    m_top_value_reg <= top_reg;
                                end
                            end
                        end else if (is_empty) begin
                            m_valid_reg     <= 1'b1;
                            m_status_reg    <= ST_EMPTY;
                            m_top_value_reg <= '0;
                            m_top_valid_reg <= 1'b0;
                            m_count_reg     <= '0;
                        end else if (occ_reg == CNT_W'(1)) begin
                            occ_reg         <= '0;
                            top_reg         <= '0;
                            top_idx_reg     <= '0;
                            m_valid_reg     <= 1'b1;
                            m_status_reg    <= ST_DONE;
                            m_top_value_reg <= '0;
                            m_top_valid_reg <= 1'b0;
                            m_count_reg     <= '0;
                        end else begin
                            scan_idx_reg <= '0;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    best_reg     <= best_next;
                    best_idx_reg <= best_idx_next;
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    if (scan_last) begin
                        // Close the gap and publish the new maximum.
                        occ_reg         <= occ_dec;
                        top_reg         <= best_next;
                        top_idx_reg     <= best_idx_next;
                        m_valid_reg     <= 1'b1;
                        m_status_reg    <= ST_DONE;
                        m_top_value_reg <= best_next;
                        m_top_valid_reg <= 1'b1;
                        m_count_reg     <= COUNT_W'(occ_dec);
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_top_value = m_top_value_reg;
    assign m_top_valid = m_top_valid_reg;
    assign m_count     = m_count_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> (CNT_W'(scan_idx_reg) + CNT_W'(1)) < occ_reg)
        else $error("scan index past the remaining entries");

    a_scan_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> !m_valid_reg)
        else $error("result register busy during a scan");

    a_top_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        !is_empty |-> CNT_W'(top_idx_reg) < occ_reg)
        else $error("cached maximum index outside held entries");

    a_top_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_top_valid_reg == (m_count_reg != '0))
        else $error("top valid disagrees with count");
`endif

endmodule
